@@ rtl/dlpmc_pkg.sv @@
// ----------------------------------------------------------------------------
// dlpmc_pkg
// Shared types and constants for the debounced long-press mode cycler.
// ----------------------------------------------------------------------------
package dlpmc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PRESS      = 2'd1;

    localparam logic [7:0]  DEBOUNCE_RESET  = 8'd15;
    localparam logic [15:0] MIN_PRESS_RESET = 16'd27;
    localparam logic [7:0]  AGREE_MAX       = 8'hFF;
    localparam logic [15:0] PRESS_MAX       = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_BINARY  = 2'd1,
        MODE_STOPPED = 2'd2,
        MODE_ASCII   = 2'd3
    } mode_t;

    typedef struct packed {
        logic        previous_sample;
        logic [7:0]  agree_count;
        logic        level;
        logic [15:0] press_ticks;
        mode_t       mode_state;
    } state_t;

    typedef struct packed {
        logic [7:0]  debounce_count;
        logic [15:0] min_press;
    } cfg_t;

    typedef struct packed {
        logic  debounced_level;
        mode_t mode;
        logic  mode_advanced;
        logic  binary_enable;
        logic  ascii_enable;
    } result_t;

endpackage

@@ rtl/dlpmc_step.sv @@
// ----------------------------------------------------------------------------
// dlpmc_step
// One sample tick: debouncer, press counter and mode advance, all
// combinational from the current state and the sample.
// ----------------------------------------------------------------------------
module dlpmc_step
    import dlpmc_pkg::*;
(
    input  state_t  state,
    input  cfg_t    cfg,
    input  logic    sample,
    output state_t  state_next,
    output result_t result
);

    logic [7:0] agree_base;
    logic [8:0] agree_inc;
    logic [7:0] agree_sat;
    logic       flip;
    logic       counting;
    logic       bump;
    logic       released;
    logic       level_new;
    logic [15:0] press_new;
    logic       advance;

    always_comb
    begin
        // Agreement run restarts on any change of the raw sample.
        agree_base = (sample != state.previous_sample) ? 8'd0 : state.agree_count;
        agree_inc  = {1'b0, agree_base} + 9'd1;
        agree_sat  = agree_inc[8] ? AGREE_MAX : agree_inc[7:0];
        flip       = (agree_sat >= cfg.debounce_count);
        // Only samples that disagree with the level run the counter.
        counting   = (sample != state.level);

        level_new = (counting && flip) ? sample : state.level;
        released  = counting && flip && !sample;
        bump      = sample && (state.level || flip);

        press_new = state.press_ticks;
        if (bump && (state.press_ticks != PRESS_MAX))
        begin
            press_new = state.press_ticks + 16'd1;
        end

        advance = !level_new && released && (press_new >= cfg.min_press);

        state_next.previous_sample = sample;
        state_next.agree_count     = counting ? (flip ? 8'd0 : agree_sat) : agree_base;
        state_next.level           = level_new;
        state_next.press_ticks     = level_new ? press_new : 16'd0;
        state_next.mode_state      = advance ? mode_t'(state.mode_state + 2'd1)
                                             : state.mode_state;

        result.debounced_level = level_new;
        result.mode            = state_next.mode_state;
        result.mode_advanced   = advance;
        result.binary_enable   = (state_next.mode_state == MODE_BINARY);
        result.ascii_enable    = (state_next.mode_state == MODE_ASCII);
    end

endmodule

@@ rtl/debounced_long_press_mode_cycler_top.sv @@
// ----------------------------------------------------------------------------
// debounced_long_press_mode_cycler_top
// Button debouncer with press-length qualified mode cycling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/raw_sample): one word per sample tick
//   of the raw button pin, 1 = pressed.
//   Output channel (out_valid/out_ready/...): exactly one word per input
//   word, carrying the debounced level, the current mode (off, binary
//   stream, stopped, ascii stream), a one-tick mode_advanced flag and the
//   two stream enables decoded from the mode.
//   Config port (cfg_we/cfg_index/cfg_wdata): index 0 debounce_count,
//   index 1 min_press; other indexes are ignored. Write only while idle.
// Timing:
//   Sample is captured in an input register, then one short pass of
//   counter/compare logic updates the state and loads the result register.
//   An accepted sample passes the input register and then the result
//   register; throughput is one word per cycle while out_ready is high.
//   When the receiver stalls, the result register and input register hold;
//   in_ready drops only once both are full.
// Reset:
//   Debouncer released, counters zero, mode off, debounce_count 15,
//   min_press 27, both channels empty.
// ----------------------------------------------------------------------------
module debounced_long_press_mode_cycler_top
    import dlpmc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   raw_sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   debounced_level,
    output logic [1:0]             mode,
    output logic                   mode_advanced,
    output logic                   binary_enable,
    output logic                   ascii_enable
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t result_reg;
    logic    in_valid_reg;
    logic    sample_reg;
    logic    out_valid_reg;
    logic    out_load;
    logic    in_load;

    // Result register frees up when empty or being drained this cycle.
    assign out_load = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || out_load;
    assign in_load  = in_valid && in_ready;

    dlpmc_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .sample     (sample_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_count <= DEBOUNCE_RESET;
            cfg_reg.min_press      <= MIN_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE_COUNT: cfg_reg.debounce_count <= cfg_wdata[7:0];
                CFG_MIN_PRESS:      cfg_reg.min_press      <= cfg_wdata[15:0];
                default:            ;
            endcase
        end
    end

    // Control: valid flags and the tick state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{previous_sample: 1'b0, agree_count: 8'd0, level: 1'b0,
                               press_ticks: 16'd0, mode_state: MODE_OFF};
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            sample_reg <= raw_sample;
        end
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign debounced_level = result_reg.debounced_level;
    assign mode            = result_reg.mode;
    assign mode_advanced   = result_reg.mode_advanced;
    assign binary_enable   = result_reg.binary_enable;
    assign ascii_enable    = result_reg.ascii_enable;

endmodule

@@ tb/sv/debounced_long_press_mode_cycler_top_tb.sv @@
// ----------------------------------------------------------------------------
// debounced_long_press_mode_cycler_top_tb
// Self-checking bench for the button debouncer with long-press mode cycling.
// Samples go in over a valid/ready channel with random gaps. A local
// predictor tracks the debouncer, press counter and mode. Every output word
// is compared field by field against the predicted word, in order.
// ----------------------------------------------------------------------------
module debounced_long_press_mode_cycler_top_tb;
    import dlpmc_pkg::*;

    // Indexes the block has no register behind; writes there must be dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int IDLE_PCT      = 28;
    localparam int RANDOM_ITEMS  = 600;
    localparam int DRAIN_CYCLES  = 8;   // comfortably above the pipeline latency

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic                   raw_sample = 1'b0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic                   debounced_level;
    logic [1:0]             mode;
    logic                   mode_advanced;
    logic                   binary_enable;
    logic                   ascii_enable;

    // Predictor copy of configuration and state.
    logic [7:0]  db_limit   = DEBOUNCE_RESET;
    logic [15:0] hold_min   = MIN_PRESS_RESET;
    logic        last_raw   = 1'b0;
    logic [7:0]  agree_run  = '0;
    logic        btn_level  = 1'b0;
    logic [15:0] hold_ticks = '0;
    mode_t       cur_mode   = MODE_OFF;

    result_t expected_words[$];
    result_t want;

    bit quiet         = 1'b0;  // no idling on either side while set
    int errors        = 0;
    int samples_sent  = 0;
    int words_checked = 0;
    int advances_seen = 0;
    int reg_writes    = 0;

    always #5 clk = ~clk;

    debounced_long_press_mode_cycler_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .raw_sample      (raw_sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .debounced_level (debounced_level),
        .mode            (mode),
        .mode_advanced   (mode_advanced),
        .binary_enable   (binary_enable),
        .ascii_enable    (ascii_enable)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One more sample disagreeing with the level; 1 means the level flips.
    function automatic bit agree_step();
        int unsigned next_run;
        next_run = agree_run + 1;
        if (next_run > AGREE_MAX)
            next_run = AGREE_MAX;
        if (next_run >= db_limit)
        begin
            agree_run = '0;
            return 1'b1;
        end
        agree_run = next_run[7:0];
        return 1'b0;
    endfunction

    // Press counter holds at full scale rather than wrapping.
    function automatic void bump_hold();
        if (hold_ticks != PRESS_MAX)
            hold_ticks = hold_ticks + 16'd1;
    endfunction

    function automatic result_t predict_sample(input logic s);
        result_t    r;
        logic       released;
        logic [1:0] next_mode;
        released = 1'b0;
        if (s != last_raw)
            agree_run = '0;
        if (s)
        begin
            if (!btn_level)
            begin
                // accepting tick counts as the first pressed tick
                if (agree_step())
                begin
                    btn_level = 1'b1;
                    bump_hold();
                end
            end
            else
                bump_hold();
        end
        else if (btn_level)
        begin
            if (agree_step())
            begin
                btn_level = 1'b0;
                released  = 1'b1;
            end
        end
        last_raw = s;

        r.mode_advanced = 1'b0;
        if (!btn_level)
        begin
            if (released && hold_ticks >= hold_min)
            begin
                next_mode       = cur_mode + 2'd1;
                cur_mode        = mode_t'(next_mode);
                r.mode_advanced = 1'b1;
            end
            hold_ticks = '0;
        end
        r.debounced_level = btn_level;
        r.mode            = cur_mode;
        r.binary_enable   = (cur_mode == MODE_BINARY);
        r.ascii_enable    = (cur_mode == MODE_ASCII);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receive side: random backpressure and in-order compare
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [1:0] exp_v,
                               input logic [1:0] act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got level %0d mode %0d adv %0d",
                         $time, debounced_level, mode, mode_advanced);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("debounced_level", 2'(want.debounced_level), 2'(debounced_level));
                check_field("mode", want.mode, mode);
                check_field("mode_advanced", 2'(want.mode_advanced), 2'(mode_advanced));
                check_field("binary_enable", 2'(want.binary_enable), 2'(binary_enable));
                check_field("ascii_enable", 2'(want.ascii_enable), 2'(ascii_enable));
                words_checked++;
                if (want.mode_advanced)
                    advances_seen++;
            end
        end
        out_ready <= (!quiet && $urandom_range(99) < IDLE_PCT) ? 1'b0 : 1'b1;
    end

    // ------------------------------------------------------------------
    // Send side
    // ------------------------------------------------------------------

    // Valid is only dropped on an idle gap, so back-to-back words keep it high.
    task automatic send_sample(input logic s);
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid   <= 1'b0;
            raw_sample <= 1'($urandom_range(0, 1));   // junk while idle
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        raw_sample <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_words.push_back(predict_sample(s));
        samples_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // Register writes only with the pipe empty and settled.
    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0]  data);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DEBOUNCE_COUNT: db_limit = data[7:0];
            CFG_MIN_PRESS:      hold_min = data;
            default:            ;
        endcase
        reg_writes++;
    endtask

    // Bounce, stable press, bounce, stable release.
    task automatic press_cycle(input int bounce, input int hold, input int rest);
        repeat (bounce) send_sample(1'($urandom_range(0, 1)));
        repeat (hold) send_sample(1'b1);
        repeat (bounce) send_sample(1'($urandom_range(0, 1)));
        repeat (rest) send_sample(1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: 15 samples to accept, 27 ticks to qualify.
    task automatic test_reset_config();
        repeat (15) send_sample(1'b1);
        // upper byte must be dropped: debounce of zero
        set_reg(CFG_DEBOUNCE_COUNT, 16'hA500);
        repeat (26) send_sample(1'b1);
        send_sample(1'b0);   // 27 ticks held, exactly at the threshold
    endtask

    // Zero debounce and zero min press: every release advances, mode wraps.
    task automatic test_zero_settings();
        set_reg(CFG_MIN_PRESS, 16'h0000);
        send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b0);
        send_sample(1'b1);
        send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b1);
        send_sample(1'b0);
    endtask

    // Pending highs not counted, lows while pressed not counted,
    // spare indexes ignored.
    task automatic test_bounce_and_spares();
        set_reg(CFG_DEBOUNCE_COUNT, 16'h0003);
        set_reg(CFG_MIN_PRESS, 16'h0002);
        set_reg(CFG_SPARE_A, 16'hFFFF);
        set_reg(CFG_SPARE_B, 16'h5A5A);
        send_sample(1'b1);
        send_sample(1'b0);
        repeat (3) send_sample(1'b1);   // accepted, one tick
        send_sample(1'b0);
        send_sample(1'b1);              // two ticks
        repeat (3) send_sample(1'b0);   // qualified release
        repeat (3) send_sample(1'b1);
        repeat (3) send_sample(1'b0);   // one tick, too short
    endtask

    // Lowering debounce below a count in progress flips on the next sample.
    task automatic test_count_reached();
        set_reg(CFG_DEBOUNCE_COUNT, 16'h0008);
        repeat (5) send_sample(1'b1);
        set_reg(CFG_DEBOUNCE_COUNT, 16'h0004);
        send_sample(1'b1);
        repeat (4) send_sample(1'b0);
    endtask

    // Long holds one tick short of and exactly at a larger threshold.
    task automatic test_hold_threshold();
        set_reg(CFG_DEBOUNCE_COUNT, 16'h0001);
        set_reg(CFG_MIN_PRESS, 16'd40);
        repeat (2) send_sample(1'b0);   // start from released
        repeat (39) send_sample(1'b1);
        send_sample(1'b0);              // one tick short, no advance
        repeat (40) send_sample(1'b1);
        send_sample(1'b0);              // exactly at the threshold
    endtask

    task automatic test_random_presses();
        int          start_count;
        int          phase;
        int          db;
        int          cycles;
        int          hold;
        int          rest;
        logic [15:0] cfg_word;
        start_count = samples_sent;
        phase       = 0;
        while (samples_sent - start_count < RANDOM_ITEMS)
        begin
            // a long run with no idling on either side
            quiet = (phase >= 4 && phase < 8);
            case ($urandom_range(0, 9))
                0:       db = 0;
                1:       db = 1;
                2:       db = 255;
                default: db = $urandom_range(2, 6);
            endcase
            cfg_word      = 16'($urandom);
            cfg_word[7:0] = db[7:0];
            set_reg(CFG_DEBOUNCE_COUNT, cfg_word);
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       set_reg(CFG_MIN_PRESS, 16'h0000);
                    1:       set_reg(CFG_MIN_PRESS, 16'hFFFF);
                    2:       set_reg(CFG_MIN_PRESS, 16'($urandom));
                    default: set_reg(CFG_MIN_PRESS, 16'($urandom_range(0, 12)));
                endcase
            end
            if ($urandom_range(0, 4) == 0)
                set_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));

            cycles = (db == 255) ? 1 : $urandom_range(2, 5);
            repeat (cycles)
            begin
                hold = db + ((hold_min <= 12) ? $urandom_range(0, hold_min + 4)
                                              : $urandom_range(0, 20));
                // now and then a release cut short by new activity
                rest = ($urandom_range(0, 4) == 0) ? $urandom_range(0, db)
                                                   : db + $urandom_range(0, 4);
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 8)) send_sample(1'($urandom_range(0, 1)));
                else
                    press_cycle($urandom_range(0, 3), hold, rest);
                if ($urandom_range(0, 5) == 0)
                    wait_drained();   // sender holds until every word is back
            end
            phase++;
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_zero_settings();
        test_bounce_and_spares();
        test_count_reached();
        test_random_presses();
        test_hold_threshold();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            $display("%0t: %0d words never arrived, expected 0 outstanding, got %0d",
                     $time, expected_words.size(), expected_words.size());
            errors++;
        end

        $display("Ran %0d samples, %0d words checked, %0d mode advances, %0d register writes.",
                 samples_sent, words_checked, advances_seen, reg_writes);
        $display("Covered reset settings, zero and extreme debounce, press thresholds, bounce.");
        if (errors == 0)
            $display("debounced_long_press_mode_cycler_top regression: pass");
        else
            $display("debounced_long_press_mode_cycler_top regression: fail");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #50000000;
        $display("%0t: timeout", $time);
        $display("debounced_long_press_mode_cycler_top regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/dlpmc_pkg.sv
rtl/dlpmc_step.sv
rtl/debounced_long_press_mode_cycler_top.sv
tb/sv/debounced_long_press_mode_cycler_top_tb.sv
